/* sv/vca_pkg.sv */
// ----------------------------------------------------------------------------
// vca_pkg
// Types and constants shared by the voice channel allocator modules.
// ----------------------------------------------------------------------------
package vca_pkg;

   localparam int SLOT_W  = 6;
   localparam int FIELD_W = 16;

   // request function codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // entry mode and play state codes
   localparam logic [FIELD_W-1:0] MODE_STEAL   = 16'd1;
   localparam logic [FIELD_W-1:0] RUN_RELEASE  = 16'd1;
   localparam logic [FIELD_W-1:0] RUN_PLAY     = 16'd2;
   localparam logic [FIELD_W-1:0] RUN_RESERVED = 16'd3;

   typedef struct packed {
      logic               busy;
      logic [FIELD_W-1:0] mode;
      logic [FIELD_W-1:0] level;
      logic [FIELD_W-1:0] run;
      logic [FIELD_W-1:0] rank;
      logic [FIELD_W-1:0] sound;
      logic [FIELD_W-1:0] variant;
   } entry_type;

   // per-entry verdicts from the compare unit
   typedef struct packed {
      logic retrig;
      logic free;
      logic steal_now;
      logic grp1;
      logic grp2;
      logic grp3;
   } match_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic found;
   } seq_status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RETRIG,
      S_FREE,
      S_STEAL
   } state_type;

endpackage

/* sv/vca_table.sv */
// ----------------------------------------------------------------------------
// vca_table
// Channel entry memory with one write port and one registered read port.
// Entries never written read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
module vca_table #(
   parameter int NUM_CHANNELS = 48,
   parameter int IDX_W        = $clog2(NUM_CHANNELS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  vca_pkg::entry_type   wr_data,
   input  logic [IDX_W-1:0]     rd_addr,
   output vca_pkg::entry_type   rd_data
);
   import vca_pkg::*;

   entry_type mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] vld_ff;
   entry_type rd_ff;
   logic rvld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rvld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rvld_ff ? rd_ff : '0;

endmodule

/* sv/vca_match.sv */
// ----------------------------------------------------------------------------
// vca_match
// Shared compare unit: classifies one table entry against the request.
// ----------------------------------------------------------------------------
module vca_match (
   input  vca_pkg::entry_type                entry,
   input  logic [vca_pkg::FIELD_W-1:0]       sound_id,
   input  logic [vca_pkg::FIELD_W-1:0]       variant,
   input  logic [vca_pkg::FIELD_W-1:0]       request_rank,
   output vca_pkg::match_type                verdict
);
   import vca_pkg::*;

   logic is_steal_mode;
   logic is_play;
   logic is_release;
   logic rank_ok;

   always_comb begin
      is_steal_mode = entry.mode == MODE_STEAL;
      is_play       = entry.run == RUN_PLAY;
      is_release    = entry.run == RUN_RELEASE;
      rank_ok       = request_rank >= entry.rank;

      verdict.retrig    = is_play && entry.sound == sound_id && entry.variant == variant;
      verdict.free      = !entry.busy && entry.run != RUN_RESERVED;
      verdict.steal_now = is_steal_mode && is_release;
      verdict.grp1      = !is_steal_mode && is_release;
      verdict.grp2      = is_steal_mode && is_play && rank_ok;
      verdict.grp3      = !is_steal_mode && is_play && rank_ok;
   end

endmodule

/* sv/vca_seq.sv */
// ----------------------------------------------------------------------------
// vca_seq
// Scan sequencer: walks the cursor through the retrigger, free and steal
// passes, one entry a cycle, and tracks the best steal candidates.
// ----------------------------------------------------------------------------
module vca_seq #(
   parameter int NUM_CHANNELS = 48,
   parameter int IDX_W        = $clog2(NUM_CHANNELS)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          start_retrig,
   input  vca_pkg::match_type            verdict,
   input  logic [vca_pkg::FIELD_W-1:0]   entry_level,
   output logic [IDX_W-1:0]              rd_addr,
   output logic [IDX_W-1:0]              done_chan,
   output vca_pkg::seq_status_type       status
);
   import vca_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);

   state_type state_ff, state_in;
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic [IDX_W-1:0] count_ff, count_in;

   logic [IDX_W-1:0]   cand1_ff, cand2_ff, cand3_ff;
   logic [IDX_W-1:0]   cand1_in, cand2_in, cand3_in;
   logic [FIELD_W-1:0] best1_ff, best2_ff, best3_ff;
   logic [FIELD_W-1:0] best1_in, best2_in, best3_in;
   logic               have1_ff, have2_ff, have3_ff;
   logic               have1_in, have2_in, have3_in;

   logic             last;
   logic             hit;
   logic             advance;
   logic [IDX_W-1:0] cursor_inc;
   logic             upd1, upd2, upd3;

   always_comb begin
      last       = count_ff == LAST_IDX;
      cursor_inc = (cursor_ff == LAST_IDX) ? '0 : cursor_ff + 1'b1;
      unique case (state_ff)
         S_RETRIG: hit = verdict.retrig;
         S_FREE:   hit = verdict.free;
         S_STEAL:  hit = verdict.steal_now;
         default:  hit = 1'b0;
      endcase
      upd1 = state_ff == S_STEAL && verdict.grp1 && (!have1_ff || entry_level < best1_ff);
      upd2 = state_ff == S_STEAL && verdict.grp2 && (!have2_ff || entry_level < best2_ff);
      upd3 = state_ff == S_STEAL && verdict.grp3 && (!have3_ff || entry_level < best3_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = start_retrig ? S_RETRIG : S_FREE;
            end
         end
         S_RETRIG: begin
            if (hit) state_in = S_IDLE;
            else if (last) state_in = S_FREE;
         end
         S_FREE: begin
            if (hit) state_in = S_IDLE;
            else if (last) state_in = S_STEAL;
         end
         S_STEAL: begin
            if (hit || last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      advance      = state_ff != S_IDLE && !hit;
      status.idle  = state_ff == S_IDLE;
      status.done  = 1'b0;
      status.found = 1'b0;
      done_chan    = '0;
      if (hit) begin
         status.done  = 1'b1;
         status.found = 1'b1;
         done_chan    = cursor_ff;
      end else if (state_ff == S_STEAL && last) begin
         status.done = 1'b1;
         // group order decides, current entry included
         if (upd1 || have1_ff) begin
            status.found = 1'b1;
            done_chan    = upd1 ? cursor_ff : cand1_ff;
         end else if (upd2 || have2_ff) begin
            status.found = 1'b1;
            done_chan    = upd2 ? cursor_ff : cand2_ff;
         end else if (upd3 || have3_ff) begin
            status.found = 1'b1;
            done_chan    = upd3 ? cursor_ff : cand3_ff;
         end
      end
      cursor_in = advance ? cursor_inc : cursor_ff;
      rd_addr   = cursor_in;
      count_in  = (state_ff == S_IDLE || hit || last) ? '0 : count_ff + 1'b1;
   end

   always_comb begin
      cand1_in = upd1 ? cursor_ff : cand1_ff;
      cand2_in = upd2 ? cursor_ff : cand2_ff;
      cand3_in = upd3 ? cursor_ff : cand3_ff;
      best1_in = upd1 ? entry_level : best1_ff;
      best2_in = upd2 ? entry_level : best2_ff;
      best3_in = upd3 ? entry_level : best3_ff;
      have1_in = start ? 1'b0 : (have1_ff || upd1);
      have2_in = start ? 1'b0 : (have2_ff || upd2);
      have3_in = start ? 1'b0 : (have3_ff || upd3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cursor_ff <= '0;
         count_ff  <= '0;
         have1_ff  <= 1'b0;
         have2_ff  <= 1'b0;
         have3_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         count_ff  <= count_in;
         have1_ff  <= have1_in;
         have2_ff  <= have2_in;
         have3_ff  <= have3_in;
      end
   end

   always_ff @(posedge clock) begin
      cand1_ff <= cand1_in;
      cand2_ff <= cand2_in;
      cand3_ff <= cand3_in;
      best1_ff <= best1_in;
      best2_ff <= best2_in;
      best3_ff <= best3_in;
   end

endmodule

/* sv/voice_channel_allocator_unit.sv */
// ----------------------------------------------------------------------------
// voice_channel_allocator_unit
// Voice channel table with round-robin retrigger, free and steal scans.
// ----------------------------------------------------------------------------
// Write word: accepted with no result; the next word may follow at once.
// Allocate word: one table entry per cycle through the shared compare unit; a
// result is registered when a scan hits or when the steal pass ends.
// The scan cursor and table read port set the scan order; one allocate at a time.
// Input holds off while a result word waits for rsp_ready.
// Reset (synchronous) clears the cursor and marks every entry free at once.
// ----------------------------------------------------------------------------
module voice_channel_allocator_unit #(
   parameter int NUM_CHANNELS = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [vca_pkg::SLOT_W-1:0]    req_slot,
   input  logic                          req_busy_req,
   input  logic [vca_pkg::FIELD_W-1:0]   req_mode_word,
   input  logic [vca_pkg::FIELD_W-1:0]   req_level,
   input  logic [vca_pkg::FIELD_W-1:0]   req_run_state,
   input  logic [vca_pkg::FIELD_W-1:0]   req_entry_rank,
   input  logic [vca_pkg::FIELD_W-1:0]   req_sound_id,
   input  logic [vca_pkg::FIELD_W-1:0]   req_variant,
   input  logic [vca_pkg::FIELD_W-1:0]   req_request_rank,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vca_pkg::SLOT_W-1:0]    rsp_channel,
   output logic                          rsp_found
);
   import vca_pkg::*;

   localparam int IDX_W = $clog2(NUM_CHANNELS);

   logic               req_accept;
   logic               wr_en;
   entry_type          wr_data;
   entry_type          rd_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   done_chan;
   match_type          verdict;
   seq_status_type     status;

   logic [FIELD_W-1:0] sound_ff, sound_in;
   logic [FIELD_W-1:0] variant_ff, variant_in;
   logic [FIELD_W-1:0] rank_ff, rank_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]  rsp_channel_ff, rsp_channel_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               alloc_start;

   always_comb begin
      req_ready   = status.idle && (!rsp_valid_ff || rsp_ready);
      req_accept  = req_valid && req_ready;
      alloc_start = req_accept && req_func == FUNC_ALLOC;
      // drop writes beyond the table
      wr_en       = req_accept && req_func == FUNC_WRITE && int'(req_slot) < NUM_CHANNELS;
      wr_data.busy    = req_busy_req;
      wr_data.mode    = req_mode_word;
      wr_data.level   = req_level;
      wr_data.run     = req_run_state;
      wr_data.rank    = req_entry_rank;
      wr_data.sound   = req_sound_id;
      wr_data.variant = req_variant;

      sound_in   = alloc_start ? req_sound_id : sound_ff;
      variant_in = alloc_start ? req_variant : variant_ff;
      rank_in    = alloc_start ? req_request_rank : rank_ff;

      rsp_valid_in   = status.done ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_channel_in = status.done ? SLOT_W'(done_chan) : rsp_channel_ff;
      rsp_found_in   = status.done ? status.found : rsp_found_ff;
   end

   vca_table #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .IDX_W        (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_slot)),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   vca_match u_match (
      .entry        (rd_data),
      .sound_id     (sound_ff),
      .variant      (variant_ff),
      .request_rank (rank_ff),
      .verdict      (verdict)
   );

   vca_seq #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .IDX_W        (IDX_W)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (alloc_start),
      .start_retrig (req_sound_id != '0),
      .verdict      (verdict),
      .entry_level  (rd_data.level),
      .rd_addr      (rd_addr),
      .done_chan    (done_chan),
      .status       (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sound_ff       <= sound_in;
      variant_ff     <= variant_in;
      rank_ff        <= rank_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_found_ff   <= rsp_found_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_channel = rsp_channel_ff;
   assign rsp_found   = rsp_found_ff;

   // a finished scan never lands on a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      status.done |-> !rsp_valid_ff)
      else $error("scan finished while a result word was pending");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      int'(rd_addr) < NUM_CHANNELS)
      else $error("scan cursor out of range");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      status.done && !status.found |-> done_chan == '0)
      else $error("miss reported with nonzero channel");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      alloc_start |=> !req_ready)
      else $error("new word accepted during a scan");

endmodule
